>>> sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Transaction structs, operation and status codes, field widths.
// ----------------------------------------------------------------------------
package spq_pkg;

  // payload field widths
  localparam int DATA_BITS     = 32;
  localparam int PRIORITY_BITS = 16;
  localparam int FUNC_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_W       = 5;

  // default queue depth
  localparam int CAPACITY_DEF  = 16;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  // input transaction
  typedef struct packed {
    func_t                     func;
    logic [DATA_BITS-1:0]      data_in;
    logic [PRIORITY_BITS-1:0]  priority_in;
  } in_t;

  // result transaction
  typedef struct packed {
    status_t                   status;
    logic [DATA_BITS-1:0]      data_out;
    logic [PRIORITY_BITS-1:0]  priority_out;
    logic [ENTRY_W-1:0]        entry_count;
  } out_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic [DATA_BITS-1:0]      data;
    logic [PRIORITY_BITS-1:0]  prio;
  } cell_cmd_t;

  // contents of one cell, as seen by its neighbours
  typedef struct packed {
    logic [DATA_BITS-1:0]      data;
    logic [PRIORITY_BITS-1:0]  prio;
  } cell_entry_t;

endpackage

>>> sv/stable_priority_queue_top.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_top: bounded sorted priority queue
// A row of cells kept in non-increasing priority order; equal priorities
// leave in arrival order. Insert, remove head, clear and no-op, one result each.
//
//   channel   signals                      direction
//   in        in_valid, in_stall, in_data  transaction in, stall out
//   out       out_valid, out_stall, out_data transaction out, stall in
//
// One transaction per cycle while out_stall holds no result: all cells compare
// against the new priority at once and shift in the same edge, so the cell row
// sets the rate. Each result is registered in out_data on acceptance.
// Input is stalled only while a finished result waits behind out_stall.
// Reset (rst, synchronous) empties the queue; cell contents are not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue_top
  import spq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               accept;
  logic               full;
  logic               empty;
  out_t               result_next;
  cell_cmd_t          cmd;
  logic               out_valid_next;

  logic        [CAPACITY-1:0] occupied;
  logic        [CAPACITY-1:0] ge;
  cell_entry_t                entries [CAPACITY];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);

  // command broadcast to the cell row
  always_comb begin
    cmd.ins  = accept && (in_data.func == FUNC_INSERT) && !full;
    cmd.rem  = accept && (in_data.func == FUNC_REMOVE) && !empty;
    cmd.data = in_data.data_in;
    cmd.prio = in_data.priority_in;
  end

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic        left_ge;
    cell_entry_t left_entry;
    cell_entry_t right_entry;

    assign occupied[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_ge    = 1'b1;
      assign left_entry = entries[i];
    end else begin : g_body
      assign left_ge    = ge[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (occupied[i]),
      .left_ge     (left_ge),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .ge          (ge[i]),
      .entry       (entries[i])
    );
  end

  // count update and result assembly
  always_comb begin
    count_next               = count;
    result_next.status       = ST_OK;
    result_next.data_out     = '0;
    result_next.priority_out = '0;
    case (in_data.func)
      FUNC_INSERT: begin
        if (full) begin
          result_next.status = ST_OVERFLOW;
        end else begin
          count_next = count + 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (empty) begin
          result_next.status = ST_UNDERFLOW;
        end else begin
          result_next.data_out     = entries[0].data;
          result_next.priority_out = entries[0].prio;
          count_next               = count - 1'b1;
        end
      end
      FUNC_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
    result_next.entry_count = ENTRY_W'(count_next);
  end

  // output valid: set on accept, dropped once taken
  always_comb begin
    out_valid_next = out_valid;
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result_next;
    end
  end

  // count never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // an insert into a non-full queue adds exactly one entry
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.func == FUNC_INSERT && !full) |=>
      count == $past(count) + 1'b1)
    else $error("insert did not grow queue");

  // an overflow result is only reported while the queue is full
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_OVERFLOW) |-> full)
    else $error("overflow reported on non-full queue");

  // a remove from a non-empty queue drops exactly one entry
  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.func == FUNC_REMOVE && !empty) |=>
      count == $past(count) - 1'b1)
    else $error("remove did not shrink queue");

endmodule

>>> sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds an entry, compares it with the incoming priority and shifts with
// its neighbours on insert and remove.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic        clk,
  input  cell_cmd_t   cmd,
  input  logic        occupied,
  input  logic        left_ge,
  input  cell_entry_t left_entry,
  input  cell_entry_t right_entry,
  output logic        ge,
  output cell_entry_t entry
);

  cell_entry_t entry_next;

  // entry stays ahead of the new item when its priority is not lower
  assign ge = occupied && (entry.prio >= cmd.prio);

  // shift right on insert behind the split point, shift left on remove
  always_comb begin
    entry_next = entry;
    if (cmd.ins) begin
      if (!ge) begin
        if (left_ge) begin
          entry_next.data = cmd.data;
          entry_next.prio = cmd.prio;
        end else begin
          entry_next = left_entry;
        end
      end
    end else if (cmd.rem) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
